// ===== rtl/fenwick_prefix_sum_table_macros.svh =====
// Assertion helpers shared by the prefix-sum table modules.
`ifndef FENWICK_PREFIX_SUM_TABLE_MACROS_SVH
`define FENWICK_PREFIX_SUM_TABLE_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define FPST_ASSERT_IMP(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPST_ASSERT_NEXT(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (cons)) \
        else $error("assertion failed");

`else

`define FPST_ASSERT_IMP(lbl, clk, rstn, ant, cons)
`define FPST_ASSERT_NEXT(lbl, clk, rstn, ant, cons)

`endif

`endif

// ===== rtl/fpst_pkg.sv =====
package fpst_pkg;

    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Tree walk index: holds 1..CAPACITY plus one overshoot step.
    localparam int P_W        = ADDR_W + 2;

    localparam int REQ_W  = 2;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 32;
    localparam int SIZE_W = 11;
    localparam int LIM_W  = (SIZE_W > P_W) ? SIZE_W : P_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [SUM_W-1:0] prefix_sum;
        logic                    status;
    } t_res;

    typedef struct packed {
        logic             load;
        logic [REQ_W-1:0] load_op;
        logic             clr_step;
        logic             walk_step;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_done;
    } t_dp_sts;

endpackage

// ===== rtl/fpst_dp.sv =====
`include "fenwick_prefix_sum_table_macros.svh"

module fpst_dp import fpst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_req    i_req,
    output t_dp_sts o_sts,
    output t_word   o_acc
);

    t_word mem [CAPACITY];

    logic [P_W-1:0]    r_p;
    logic [P_W-1:0]    n_p;
    logic [P_W-1:0]    w_low;
    logic [P_W-1:0]    w_pm1;
    logic [P_W-1:0]    w_pos;
    logic [ADDR_W-1:0] w_ra;
    logic [ADDR_W-1:0] r_wa;
    logic              r_is_add;
    logic              r_wr_pend;
    logic              r_acc_pend;
    logic              w_in_range;
    logic              w_rd_en;
    t_word             r_rd;
    t_word             r_val;
    t_word             r_acc;

    assign w_pos      = P_W'(i_req.position);
    assign w_low      = r_p & (~r_p + P_W'(1));
    assign w_pm1      = r_p - P_W'(1);
    assign w_ra       = w_pm1[ADDR_W-1:0];
    assign w_in_range = (r_p != '0) && (r_p <= P_W'(CAPACITY));
    assign w_rd_en    = i_cmd.walk_step && w_in_range;

    always_comb begin
        n_p = r_p;
        if (i_cmd.load) begin
            case (i_cmd.load_op)
                REQ_ADD:   n_p = w_pos + P_W'(1);
                REQ_CLEAR: n_p = '0;
                default:   n_p = w_pos;
            endcase
        end else if (i_cmd.clr_step) begin
            n_p = r_p + P_W'(1);
        end else if (w_rd_en) begin
            // Updates climb to the parent, queries strip the lowest set bit.
            n_p = r_is_add ? (r_p + w_low) : (r_p ^ w_low);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p        <= '0;
            r_is_add   <= 1'b0;
            r_wr_pend  <= 1'b0;
            r_acc_pend <= 1'b0;
        end else begin
            r_p        <= n_p;
            r_wr_pend  <= w_rd_en && r_is_add;
            r_acc_pend <= w_rd_en && !r_is_add;
            if (i_cmd.load) begin
                r_is_add <= (i_cmd.load_op == REQ_ADD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= DATA_WIDTH'(i_req.value);
            r_acc <= '0;
        end else if (r_acc_pend) begin
            r_acc <= r_acc + r_rd;
        end
        if (w_rd_en) begin
            r_wa <= w_ra;
        end
    end

    // The write of one node overlaps the read of the next one on the walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_p[ADDR_W-1:0]] <= '0;
        end else if (r_wr_pend) begin
            mem[r_wa] <= r_rd + r_val;
        end
        if (w_rd_en) begin
            r_rd <= mem[w_ra];
        end
    end

    assign o_sts.clr_last  = (r_p[ADDR_W-1:0] == ADDR_W'(CAPACITY - 1));
    assign o_sts.walk_done = !w_in_range;
    assign o_acc           = r_acc;

    `FPST_ASSERT_IMP(a_no_wr_clash, i_clk, i_rst_n, i_cmd.clr_step, !r_wr_pend)
    `FPST_ASSERT_IMP(a_load_drained, i_clk, i_rst_n, i_cmd.load, !r_wr_pend && !r_acc_pend)

endmodule

// ===== rtl/fpst_ctrl.sv =====
`include "fenwick_prefix_sum_table_macros.svh"

module fpst_ctrl import fpst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd,
    output logic              o_done,
    output logic              o_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CLR  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic              r_clr_rsp;
    logic              n_clr_rsp;
    logic              r_done;
    logic              n_done;
    logic              r_status;
    logic              n_status;
    logic [SIZE_W-1:0] r_cfg;
    logic [LIM_W-1:0]  w_cfg;
    logic [LIM_W-1:0]  w_live;
    logic [LIM_W-1:0]  w_pos;
    logic              w_accept;
    logic              w_err;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;

    assign w_cfg  = LIM_W'(r_cfg);
    assign w_live = (w_cfg > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : w_cfg;
    assign w_pos  = LIM_W'(i_req.position);

    always_comb begin
        case (i_req.req_type)
            REQ_CLEAR: w_err = 1'b0;
            REQ_ADD:   w_err = (w_pos >= w_live);
            REQ_QUERY: w_err = (w_pos > w_live);
            default:   w_err = 1'b1;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_clr_rsp = r_clr_rsp;
        n_done    = 1'b0;
        n_status  = r_status;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_err) begin
                        n_done   = 1'b1;
                        n_status = 1'b1;
                    end else if (i_req.req_type == REQ_CLEAR) begin
                        n_state   = ST_CLR;
                        n_clr_rsp = 1'b1;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_CLR: begin
                if (i_sts.clr_last) begin
                    // The pass after reset finishes without a result beat.
                    n_state   = ST_IDLE;
                    n_done    = r_clr_rsp;
                    n_status  = 1'b0;
                    n_clr_rsp = 1'b0;
                end
            end
            ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_status = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr_rsp <= 1'b0;
            r_done    <= 1'b0;
            r_cfg     <= SIZE_RESET;
        end else begin
            r_state   <= n_state;
            r_clr_rsp <= n_clr_rsp;
            r_done    <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign o_cmd.load      = w_accept;
    assign o_cmd.load_op   = i_req.req_type;
    assign o_cmd.clr_step  = (r_state == ST_CLR);
    assign o_cmd.walk_step = (r_state == ST_WALK);
    assign o_done          = r_done;
    assign o_status        = r_status;

    `FPST_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, r_state == ST_IDLE)
    `FPST_ASSERT_NEXT(a_err_beat, i_clk, i_rst_n, w_accept && w_err, o_done && o_status)
    `FPST_ASSERT_NEXT(a_walk_entry, i_clk, i_rst_n,
        w_accept && !w_err && (i_req.req_type != REQ_CLEAR), r_state == ST_WALK)

endmodule

// ===== rtl/fenwick_prefix_sum_table.sv =====
// Channel   Direction  Handshake                    Payload
// request   in         start && !busy               i_req (t_req)
// result    out        o_res_strobe, one cycle      o_res (t_res)
// config    in         i_cfg_valid && o_cfg_ready   i_cfg_data (size_in_use)
//
// An add visits each tree node it touches (at most 11); each cycle reads one node and
// writes back the one before it. A query visits one node per set bit of the count.
// A clear zeroes one word a cycle over all 1024 words, then gives the result beat.
// After reset the same clearing pass runs with busy high and no result.
// A result beat lasts one cycle and cannot be stalled; a new request may be accepted in it.
module fenwick_prefix_sum_table import fpst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_res_strobe,
    output t_res              o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_word   w_acc;
    logic    w_status;

    fpst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_done      (o_res_strobe),
        .o_status    (w_status)
    );

    fpst_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_sts   (w_sts),
        .o_acc   (w_acc)
    );

    assign o_res.prefix_sum = SUM_W'(w_acc);
    assign o_res.status     = w_status;

endmodule

// ===== sim/tb.sv =====
module tb;
    import fpst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;
    localparam int   MAX_CLEARS = 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_req              i_req = '0;
    logic              o_res_strobe;
    t_res              o_res;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data = '0;

    fenwick_prefix_sum_table i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the table: plain element values, not tree nodes.
    t_word             element_sum [CAPACITY];
    logic [SIZE_W-1:0] size_reg = SIZE_RESET;

    t_req        pending_reqs [$];
    t_res        expected_results [$];
    t_res        next_expected;
    int unsigned sender_idle_pct = 36;
    int          clears_left = MAX_CLEARS;
    int          fail_count = 0;

    initial begin
        foreach (element_sum[i]) element_sum[i] = '0;
    end

    function automatic t_res apply_request(input t_req r);
        t_res        res;
        t_word       acc;
        int unsigned lim;
        res = '0;
        res.status = ST_OK;
        acc = '0;
        lim = (size_reg > CAPACITY) ? CAPACITY : size_reg;
        case (r.req_type)
            REQ_CLEAR: begin
                foreach (element_sum[i]) element_sum[i] = '0;
            end
            REQ_ADD: begin
                if (r.position >= lim) res.status = ST_REJECT;
                else element_sum[r.position] = element_sum[r.position] + t_word'(r.value);
            end
            REQ_QUERY: begin
                if (r.position > lim) begin
                    res.status = ST_REJECT;
                end else begin
                    for (int i = 0; i < r.position; i++) acc = acc + element_sum[i];
                    res.prefix_sum = acc;
                end
            end
            default: res.status = ST_REJECT;
        endcase
        return res;
    endfunction

    task automatic flag_error(input string msg);
        $error("%s", msg);
        fail_count++;
    endtask

    // Request driver. A beat is taken at an edge where start is high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_results.push_back(apply_request(i_req));
            if (!start || !busy) begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    i_req <= pending_reqs.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Results cannot be stalled, so every strobe is a beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            if (expected_results.size() == 0) begin
                flag_error("result beat with no request outstanding");
            end else begin
                next_expected = expected_results.pop_front();
                if (o_res.prefix_sum !== next_expected.prefix_sum)
                    flag_error($sformatf("prefix_sum: expected %0d, got %0d",
                                         next_expected.prefix_sum, o_res.prefix_sum));
                if (o_res.status !== next_expected.status)
                    flag_error($sformatf("status: expected %0d, got %0d",
                                         next_expected.status, o_res.status));
            end
        end
    end

    task automatic queue_req(input logic [REQ_W-1:0] kind, input int unsigned pos,
                             input logic [VAL_W-1:0] val);
        t_req r;
        r.req_type = kind;
        r.position = POS_W'(pos);
        r.value    = val;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(9, 0))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Mostly in-range adds and queries; the rest are rejects, clears and unknown types.
    task automatic queue_random_req(input int unsigned lim);
        int unsigned pick;
        int unsigned pos;
        pick = $urandom_range(99, 0);
        if (pick < 2 && clears_left > 0) begin
            clears_left--;
            queue_req(REQ_CLEAR, $urandom_range(2047, 0), $urandom());
        end else if (pick < 50) begin
            if (lim > 0 && $urandom_range(99, 0) < 90) pos = $urandom_range(lim - 1, 0);
            else pos = $urandom_range(2047, lim);
            queue_req(REQ_ADD, pos, random_value());
        end else if (pick < 97) begin
            case ($urandom_range(9, 0))
                0:       pos = lim;
                1:       pos = $urandom_range(2047, lim + 1);
                default: pos = $urandom_range(lim, 0);
            endcase
            queue_req(REQ_QUERY, pos, $urandom());
        end else begin
            queue_req(REQ_UNKNOWN, $urandom_range(2047, 0), $urandom());
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_results.size() != 0);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] val);
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_reg = val;
    endtask

    task automatic run_phase(input int unsigned new_size, input int unsigned n_items,
                             input int unsigned idle_pct);
        int unsigned lim;
        write_size(SIZE_W'(new_size));
        sender_idle_pct = idle_pct;
        lim = (new_size > CAPACITY) ? CAPACITY : new_size;
        repeat (n_items) queue_random_req(lim);
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset size.
        queue_req(REQ_QUERY, 0, 32'h0);
        queue_req(REQ_QUERY, 1024, 32'hffff_ffff);
        queue_req(REQ_QUERY, 1025, 32'h0);
        queue_req(REQ_QUERY, 2047, 32'h0);
        queue_req(REQ_ADD, 0, 32'h7fff_ffff);
        queue_req(REQ_ADD, 1023, 32'h8000_0000);
        queue_req(REQ_ADD, 1024, 32'h5);
        queue_req(REQ_ADD, 2047, 32'hffff_ffff);
        queue_req(REQ_ADD, 511, 32'hffff_ffff);
        queue_req(REQ_ADD, 0, 32'h1);
        queue_req(REQ_QUERY, 1, 32'h0);
        queue_req(REQ_QUERY, 512, 32'h0);
        queue_req(REQ_QUERY, 1023, 32'h0);
        queue_req(REQ_QUERY, 1024, 32'h0);
        queue_req(REQ_UNKNOWN, 2047, 32'hffff_ffff);
        queue_req(REQ_UNKNOWN, 0, 32'h0);
        queue_req(REQ_CLEAR, 2047, 32'hffff_ffff);
        queue_req(REQ_QUERY, 1024, 32'h0);
        queue_req(REQ_ADD, 700, 32'h1234_5678);
        queue_req(REQ_QUERY, 701, 32'h0);
        queue_req(REQ_CLEAR, 0, 32'h0);
        queue_req(REQ_QUERY, 701, 32'h0);
        wait_drained();

        // Small sizes come before the last full-size phase so that adds made
        // under a small size must show up in later wide queries.
        run_phase(1000, 400, 36);
        run_phase(2047, 350, 36);
        run_phase(0, 50, 80);
        run_phase(1, 100, 80);
        run_phase(13, 400, 0);
        run_phase(1024, 500, 0);

        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
